### src/qas_pkg.sv
// Shared types and constants for the quadratic assignment search block.
// No dependencies.
`default_nettype none
package qas_pkg;
   localparam int IDX_BITS  = 3;
   localparam int SIZE_BITS = 4;
   localparam int COST_BITS = 38;
   localparam int VAL_BITS  = 16;

   // matrix dimension and stored entry width
   localparam int MAX_SIZE   = 8;
   localparam int VALUE_BITS = 16;

   localparam logic [1:0] OP_LOAD_DIST = 2'd0;
   localparam logic [1:0] OP_LOAD_COST = 2'd1;
   localparam logic [1:0] OP_START     = 2'd2;

   localparam logic [COST_BITS-1:0] COST_ALL_ONES = {COST_BITS{1'b1}};

   typedef struct packed {
      logic [1:0]          op;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
      logic [VAL_BITS-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  position;
      logic [SIZE_BITS-1:0] location;
      logic [COST_BITS-1:0] total_cost;
      logic                 last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // write a table entry from the request word
      logic init;         // identity perms, best cost all ones
      logic clr_sum;      // clear accumulator, pair index to zero
      logic acc;          // issue one table read pair / accumulate
      logic finish_perm;  // compare, update best
      logic step_perm;    // advance permutation one step
      logic emit_load;    // load output register for position
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pair_done;    // last pair of the current permutation issued
      logic acc_idle;     // accumulator pipeline empty
      logic perm_done;    // step found no successor
      logic step_done;    // permutation step finished
   } dp_stat_type;
endpackage
`default_nettype wire

### src/qas_datapath.sv
// Datapath: matrix memories, permutation registers, multiply-accumulate and
// best-result tracking. Uses qas_pkg.
`default_nettype none
module qas_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  qas_pkg::ctl_cmd_type cmd,
   input  wire  qas_pkg::req_word_type req_word,
   input  wire  [qas_pkg::SIZE_BITS-1:0] n_act,
   input  wire  [qas_pkg::IDX_BITS-1:0]  emit_pos,
   output qas_pkg::dp_stat_type       stat,
   output qas_pkg::rsp_word_type      out_word
);
   import qas_pkg::*;

   localparam int PB    = $clog2(MAX_SIZE);
   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AB    = $clog2(DEPTH);
   localparam int PW    = 2 * VALUE_BITS;

   logic [VALUE_BITS-1:0] dist_mem [DEPTH];
   logic [VALUE_BITS-1:0] cost_mem [DEPTH];
   logic [VALUE_BITS-1:0] d_rd_ff, c_rd_ff;

   logic [PB-1:0] perm_ff [MAX_SIZE];
   logic [PB-1:0] perm_in [MAX_SIZE];
   logic [PB-1:0] best_ff [MAX_SIZE];
   logic [COST_BITS-1:0] best_cost_ff, sum_ff, sum_in;
   logic [PB-1:0] i_ff, j_ff;
   logic v1_ff, v2_ff;
   logic [PW-1:0] prod_ff;
   logic [PB:0] nm1;

   // step sequencer state: 0 scan k, 1 scan l, 2 reverse
   logic [1:0] ph_ff;
   logic [PB-1:0] k_ff, l_ff, lo_ff, hi_ff;

   logic ld_ok;
   logic [AB-1:0] ld_addr, d_addr, c_addr;
   logic [COST_BITS:0] add_w;

   assign nm1 = (PB+1)'(n_act - 4'd1);
   assign ld_ok = (32'(req_word.row) < MAX_SIZE) && (32'(req_word.col) < MAX_SIZE);
   assign ld_addr = AB'(32'(req_word.row) * MAX_SIZE + 32'(req_word.col));
   assign d_addr  = AB'(32'(i_ff) * MAX_SIZE + 32'(j_ff));
   assign c_addr  = AB'(32'(perm_ff[i_ff]) * MAX_SIZE + 32'(perm_ff[j_ff]));

   always_ff @(posedge clock) begin
      if (cmd.load && ld_ok && req_word.op == OP_LOAD_DIST)
         dist_mem[ld_addr] <= req_word.value[VALUE_BITS-1:0];
      if (cmd.load && ld_ok && req_word.op == OP_LOAD_COST)
         cost_mem[ld_addr] <= req_word.value[VALUE_BITS-1:0];
      d_rd_ff <= dist_mem[d_addr];
      c_rd_ff <= cost_mem[c_addr];
      prod_ff <= PW'(d_rd_ff) * PW'(c_rd_ff);
   end

   // saturating accumulate
   always_comb begin
      add_w = {1'b0, sum_ff} + (COST_BITS+1)'(prod_ff);
      sum_in = sum_ff;
      if (cmd.clr_sum) sum_in = '0;
      else if (v2_ff) sum_in = add_w[COST_BITS] ? COST_ALL_ONES : add_w[COST_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         sum_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         v1_ff <= cmd.acc;
         v2_ff <= v1_ff;
         sum_ff <= sum_in;
         if (cmd.clr_sum) begin
            i_ff <= '0;
            j_ff <= '0;
         end else if (cmd.acc) begin
            if ({1'b0, j_ff} == nm1) begin
               j_ff <= '0;
               i_ff <= i_ff + 1'b1;
            end else
               j_ff <= j_ff + 1'b1;
         end
      end
   end

   // status flags come from registers only; acc_idle is sampled in the wait
   // state, each other flag in the state that issues the matching command
   assign stat.pair_done = ({1'b0, i_ff} == nm1) && ({1'b0, j_ff} == nm1);
   assign stat.acc_idle  = !v1_ff && !v2_ff;

   // permutation step: one compare and at most one swap per cycle of step_perm
   always_comb begin
      for (int q = 0; q < MAX_SIZE; q++) perm_in[q] = perm_ff[q];
      if (ph_ff == 2'd1 && perm_ff[l_ff] > perm_ff[k_ff]) begin
         perm_in[k_ff] = perm_ff[l_ff];
         perm_in[l_ff] = perm_ff[k_ff];
      end else if (ph_ff == 2'd2 && lo_ff < hi_ff) begin
         perm_in[lo_ff] = perm_ff[hi_ff];
         perm_in[hi_ff] = perm_ff[lo_ff];
      end
   end

   logic k_hit, l_hit, rev_end;
   assign k_hit   = (k_ff == '0) || (perm_ff[k_ff - 1'b1] < perm_ff[k_ff]);
   assign l_hit   = perm_ff[l_ff] > perm_ff[k_ff];
   assign rev_end = !(lo_ff < hi_ff) || (lo_ff + 1'b1 >= hi_ff);
   logic found_ff;
   assign stat.step_done = ph_ff == 2'd2 && rev_end;
   assign stat.perm_done = !found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 2'd0;
         found_ff <= 1'b1;
         for (int q = 0; q < MAX_SIZE; q++) begin
            perm_ff[q] <= PB'(q);
            best_ff[q] <= PB'(q);
         end
         best_cost_ff <= COST_ALL_ONES;
         k_ff <= '0; l_ff <= '0; lo_ff <= '0; hi_ff <= '0;
      end else begin
         if (cmd.init) begin
            for (int q = 0; q < MAX_SIZE; q++) begin
               perm_ff[q] <= PB'(q);
               best_ff[q] <= PB'(q);
            end
            best_cost_ff <= COST_ALL_ONES;
            ph_ff <= 2'd0;
            k_ff <= nm1[PB-1:0];
         end else if (cmd.finish_perm) begin
            if (sum_ff < best_cost_ff) begin
               best_cost_ff <= sum_ff;
               for (int q = 0; q < MAX_SIZE; q++) best_ff[q] <= perm_ff[q];
            end
            ph_ff <= 2'd0;
            k_ff <= nm1[PB-1:0];
         end else if (cmd.step_perm) begin
            for (int q = 0; q < MAX_SIZE; q++) perm_ff[q] <= perm_in[q];
            case (ph_ff)
               2'd0: begin
                  if (k_hit) begin
                     hi_ff <= nm1[PB-1:0];
                     if (k_ff == '0) begin
                        found_ff <= 1'b0;
                        lo_ff <= '0;
                        ph_ff <= 2'd2;
                     end else begin
                        found_ff <= 1'b1;
                        k_ff <= k_ff - 1'b1;
                        l_ff <= nm1[PB-1:0];
                        ph_ff <= 2'd1;
                     end
                  end else
                     k_ff <= k_ff - 1'b1;
               end
               2'd1: begin
                  if (l_hit) begin
                     lo_ff <= k_ff + 1'b1;
                     ph_ff <= 2'd2;
                  end else
                     l_ff <= l_ff - 1'b1;
               end
               2'd2: begin
                  lo_ff <= lo_ff + 1'b1;
                  hi_ff <= hi_ff - 1'b1;
               end
               default: ph_ff <= 2'd0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_word.position   <= emit_pos;
         out_word.location   <= SIZE_BITS'(best_ff[emit_pos[PB-1:0]]) + 4'd1;
         out_word.total_cost <= best_cost_ff;
         out_word.last       <= ({1'b0, emit_pos} == 4'(nm1));
      end
   end
endmodule
`default_nettype wire

### src/qas_control.sv
// Controller state machine: sequences loads, permutation sums, steps and
// result emission. Uses qas_pkg.
`default_nettype none
module qas_control (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [1:0]                  req_op,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   input  wire  [qas_pkg::SIZE_BITS-1:0] n_act,
   input  wire  qas_pkg::dp_stat_type  stat,
   output qas_pkg::ctl_cmd_type        cmd,
   output logic [qas_pkg::IDX_BITS-1:0] emit_pos
);
   import qas_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM  = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_STEP = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0] st_ff, st_in;
   logic [IDX_BITS-1:0] pos_ff, pos_in;
   logic vld_ff, vld_in;
   logic acc_req;

   assign acc_req   = req_valid && !req_stall;
   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign emit_pos  = pos_ff;

   always_comb begin
      st_in = st_ff;
      pos_in = pos_ff;
      vld_in = vld_ff;
      cmd = '0;
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (acc_req && (req_op == OP_LOAD_DIST || req_op == OP_LOAD_COST))
               cmd.load = 1'b1;
            if (acc_req && req_op == OP_START) begin
               cmd.init = 1'b1;
               cmd.clr_sum = 1'b1;
               st_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.acc = 1'b1;
            if (stat.pair_done) st_in = S_WAIT;
         end
         S_WAIT: if (stat.acc_idle) st_in = S_CMP;
         S_CMP: begin
            cmd.finish_perm = 1'b1;
            st_in = S_STEP;
         end
         S_STEP: begin
            cmd.step_perm = 1'b1;
            if (stat.step_done) begin
               cmd.clr_sum = stat.perm_done ? 1'b0 : 1'b1;
               if (stat.perm_done) begin
                  pos_in = '0;
                  st_in = S_EMIT;
               end else
                  st_in = S_SUM;
            end
         end
         S_EMIT: begin
            if (!vld_ff || !rsp_stall) begin
               cmd.emit_load = 1'b1;
               vld_in = 1'b1;
               pos_in = pos_ff + 1'b1;
               if ({1'b0, pos_ff} == n_act - 4'd1) st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         pos_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pos_ff <= pos_in;
         vld_ff <= vld_in;
      end
   end
endmodule
`default_nettype wire

### src/quadratic_assignment_search.sv
// Exhaustive quadratic assignment search, top level.
// Request words load distance or cost entries (one per cycle when idle,
// no result) or start a search. A start holds req_stall high for the
// whole search: every permutation of the active size is visited in
// lexicographic order, each summed as n*n pairs on the single
// multiply-accumulate unit, then drained through the pipeline and
// compared with the best so far, before a permutation step moves on.
// Then n result words leave one per cycle through an output register;
// rsp_stall holds the current word and pauses emission.
// The csr_ port holds problem_size (byte address 0), reset value 8; write it
// only while idle. Synchronous reset clears control state and sets identity
// permutations and an all-ones best cost; matrices are unknown until loaded.
// Uses qas_pkg, qas_control, qas_datapath.
`default_nettype none
module quadratic_assignment_search (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  qas_pkg::req_word_type  req_word,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output qas_pkg::rsp_word_type        rsp_word,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [1:0]                   csr_paddr,
   input  wire  [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import qas_pkg::*;

   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] n_act;
   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic [IDX_BITS-1:0] emit_pos;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(size_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset)
         size_ff <= 4'd8;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         size_ff <= csr_pwdata[SIZE_BITS-1:0];
   end

   always_comb begin
      if (size_ff == '0) n_act = 4'd1;
      else if (32'(size_ff) > MAX_SIZE) n_act = SIZE_BITS'(MAX_SIZE);
      else n_act = size_ff;
   end

   qas_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_op(req_word.op),
      .rsp_valid, .rsp_stall, .n_act, .stat, .cmd, .emit_pos
   );

   qas_datapath u_dp (
      .clock, .reset, .cmd, .req_word, .n_act, .emit_pos, .stat,
      .out_word(rsp_word)
   );
endmodule
`default_nettype wire
